// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked check with a fixed message.
`define PIP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pip assertion failed");

// Clocked check with its own message.
`define PIP_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

// File: hdl/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

  // Default sizing of the vertex store and of one coordinate.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 16;

  // Request modes. The fourth code carries no meaning and is ignored.
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_TOO_FEW  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

endpackage

// File: hdl/pip_channels.sv
`timescale 1ns / 1ps

// Request channel: one beat clears the polygon, appends a vertex or asks a query.
interface pip_req_if import pip_pkg::*; #(
  parameter int CoordBits = COORD_BITS_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic signed [CoordBits-1:0] coord_x;
  logic signed [CoordBits-1:0] coord_y;

  modport source (output valid, mode, coord_x, coord_y, input ready);
  modport sink   (input valid, mode, coord_x, coord_y, output ready);
endinterface

// Result channel: one beat per query.
interface pip_res_if import pip_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic [1:0] status;

  modport source (output valid, inside_res, status, input ready);
  modport sink   (input valid, inside_res, status, output ready);
endinterface

// File: hdl/pip_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module pip_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/point_in_polygon_test.sv
`timescale 1ns / 1ps

// Point-in-polygon test by ray-casting parity.
// The request channel (req_i) carries beats that clear the stored polygon,
// append one vertex, or ask whether a query point lies inside. Vertices are
// kept in order in one RAM, and edge i joins vertex i to vertex i+1, with the
// last vertex closing back to vertex 0. Only a query produces a beat on the
// result channel (res_o): the crossing parity and a status code.
// Clear and append beats leave the sequencer idle. A query first fetches
// vertex 0, then takes each edge through a load state and two multiply
// states, in which one shared signed multiplier forms the cross-product
// terms in turn, and ends in a finish state that settles the last
// comparison and a done state that hands the result over. A query on a
// store that has overflowed or holds fewer than three vertices jumps
// to the done state. The request side is not ready while a query is
// being walked. The result sits in an output register, so further clears
// and appends are taken while it waits; a query that finishes while that
// register is still full holds until the receiver takes the waiting beat.
// Reset empties the polygon and clears the overflow flag; the vertex RAM
// itself is not cleared, as only entries below the vertex count are read.
module point_in_polygon_test import pip_pkg::*; #(
  parameter int MaxVertices = MAX_VERTICES_DEF,
  parameter int CoordBits   = COORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pip_req_if.sink   req_i,
  pip_res_if.source res_o
);

`include "assert_macros.svh"

  localparam int AddrW = $clog2(MaxVertices);
  localparam int CntW  = $clog2(MaxVertices + 1);
  // Differences of two coordinates need one bit more; products twice that.
  localparam int DiffW = CoordBits + 1;
  localparam int ProdW = 2 * DiffW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_MUL1  = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]      state_q;
  logic [CntW-1:0] count_q;
  logic            ovf_q;
  logic [AddrW-1:0] rd_ptr_q;
  logic [CntW-1:0] eidx_q;
  logic            parity_q;
  logic            pend_q;
  logic [1:0]      res_status_q;

  logic            out_valid_q;
  logic            out_inside_q;
  logic [1:0]      out_status_q;

  // Walk payload.
  logic signed [CoordBits-1:0] qx_q, qy_q;
  logic signed [CoordBits-1:0] first_x_q, first_y_q;
  logic signed [CoordBits-1:0] prev_x_q, prev_y_q;
  logic signed [DiffW-1:0]     dx_q, dyq_q, dy_q, dxq_q;
  logic                        span_q;
  logic signed [ProdW-1:0]     p1_q, p2_q;

  logic                        req_fire;
  logic                        full;
  logic                        last_edge;
  logic                        out_free;
  logic                        ram_we;
  logic [2*CoordBits-1:0]      ram_rdata;
  logic signed [CoordBits-1:0] rd_x, rd_y;
  logic signed [CoordBits-1:0] cur_x, cur_y;
  logic signed [CoordBits-1:0] lx, ly, rx, ry;
  logic                        swap;
  logic signed [DiffW-1:0]     mul_a, mul_b;
  logic signed [ProdW-1:0]     mul_p;
  logic                        cross_le;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign full        = (count_q == CntW'(MaxVertices));
  assign last_edge   = (eidx_q == count_q - CntW'(1));
  assign out_free    = !out_valid_q || res_o.ready;
  assign ram_we      = req_fire && (req_i.mode == MODE_APPEND) && !full;

  pip_ram #(
    .Width (2 * CoordBits),
    .Depth (MaxVertices)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i ({req_i.coord_y, req_i.coord_x}),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign rd_x = ram_rdata[CoordBits-1:0];
  assign rd_y = ram_rdata[2*CoordBits-1:CoordBits];

  // The closing edge returns to the saved first vertex.
  assign cur_x = last_edge ? first_x_q : rd_x;
  assign cur_y = last_edge ? first_y_q : rd_y;

  // Order the endpoints of the edge by x.
  assign swap = (cur_x < prev_x_q);
  assign lx   = swap ? cur_x : prev_x_q;
  assign ly   = swap ? cur_y : prev_y_q;
  assign rx   = swap ? prev_x_q : cur_x;
  assign ry   = swap ? prev_y_q : cur_y;

  // The shared multiplier forms (rx-lx)*(qy-ly) first, then (ry-ly)*(qx-lx).
  assign mul_a = (state_q == ST_MUL1) ? dx_q  : dy_q;
  assign mul_b = (state_q == ST_MUL1) ? dyq_q : dxq_q;
  assign mul_p = mul_a * mul_b;

  // The edge crosses the ray when q lies under or on it.
  assign cross_le = (p1_q <= p2_q);

  // Sequencer and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      rd_ptr_q     <= '0;
      eidx_q       <= '0;
      parity_q     <= 1'b0;
      pend_q       <= 1'b0;
      res_status_q <= STAT_OK;
      out_valid_q  <= 1'b0;
    end else begin
      // The products of an edge are complete once the second one is taken.
      pend_q <= (state_q == ST_MUL2);
      // The comparison of the edge whose products have just been formed
      // runs alongside the fetch of the next edge.
      if (pend_q && span_q && cross_le) begin
        parity_q <= !parity_q;
      end
      // A beat taken while the next result is handed over is replaced below.
      if (out_valid_q && res_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            unique case (req_i.mode)
              MODE_CLEAR: begin
                count_q <= '0;
                ovf_q   <= 1'b0;
              end
              MODE_APPEND: begin
                if (full) begin
                  ovf_q <= 1'b1;
                end else begin
                  count_q <= count_q + CntW'(1);
                end
              end
              MODE_QUERY: begin
                parity_q <= 1'b0;
                if (ovf_q) begin
                  res_status_q <= STAT_OVERFLOW;
                  state_q      <= ST_DONE;
                end else if (count_q < CntW'(3)) begin
                  res_status_q <= STAT_TOO_FEW;
                  state_q      <= ST_DONE;
                end else begin
                  res_status_q <= STAT_OK;
                  rd_ptr_q     <= AddrW'(1);
                  eidx_q       <= '0;
                  state_q      <= ST_FIRST;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_FIRST: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          rd_ptr_q <= rd_ptr_q + AddrW'(1);
          state_q  <= ST_MUL1;
        end
        ST_MUL1: begin
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          if (last_edge) begin
            state_q <= ST_FIN;
          end else begin
            eidx_q  <= eidx_q + CntW'(1);
            state_q <= ST_LOAD;
          end
        end
        ST_FIN: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            rd_ptr_q    <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Walk payload and result data.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      qx_q <= req_i.coord_x;
      qy_q <= req_i.coord_y;
    end
    if (state_q == ST_FIRST) begin
      first_x_q <= rd_x;
      first_y_q <= rd_y;
      prev_x_q  <= rd_x;
      prev_y_q  <= rd_y;
    end
    if (state_q == ST_LOAD) begin
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
      dx_q     <= DiffW'(rx) - DiffW'(lx);
      dyq_q    <= DiffW'(qy_q) - DiffW'(ly);
      dy_q     <= DiffW'(ry) - DiffW'(ly);
      dxq_q    <= DiffW'(qx_q) - DiffW'(lx);
      span_q   <= (lx < qx_q) && (qx_q <= rx);
    end
    if (state_q == ST_MUL1) begin
      p1_q <= mul_p;
    end
    if (state_q == ST_MUL2) begin
      p2_q <= mul_p;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_inside_q <= (res_status_q == STAT_OK) ? parity_q : 1'b0;
      out_status_q <= res_status_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.inside_res = out_inside_q;
  assign res_o.status     = out_status_q;

  // The store never holds more vertices than it has room for, and the
  // overflow flag is only ever set once it is full.
  `PIP_ASSERT_MSG(a_count_bound, count_q <= CntW'(MaxVertices), "vertex count beyond capacity")
  `PIP_ASSERT_MSG(a_ovf_full, ovf_q |-> full, "overflow flag set on a store that is not full")
  // A walk only visits edges that exist.
  `PIP_ASSERT(a_edge_bound, (state_q == ST_LOAD) |-> (eidx_q < count_q))
  // A result beat only appears when the sequencer hands one over.
  `PIP_ASSERT(a_res_source, $rose(out_valid_q) |-> $past(state_q == ST_DONE))

endmodule

// File: tb/tb_point_in_polygon_test.sv
`timescale 1ns / 1ps

// Checks the point-in-polygon block with its own crossing-parity model.
// Every request beat accepted by the block passes through the same model
// state that the block keeps. A query beat queues the answer that the block
// must give, and each result beat is checked against the oldest answer in
// that queue. Both channels idle at random, apart from one long stretch in
// the middle of the random traffic in which neither side holds back.
module tb_point_in_polygon_test;
  import pip_pkg::*;

  localparam int MAX_VERTICES = MAX_VERTICES_DEF;
  localparam int COORD_BITS   = COORD_BITS_DEF;

  // The package names only three modes; the fourth code must be ignored.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Idle rate of either channel, in percent of cycles.
  localparam int IDLE_PCT = 18;

  // QUERY_CYCLES spans the slowest query, on a full store. The limit allows
  // for several hundred of those, with gaps and stalls, several times over.
  localparam int QUERY_CYCLES = 3 * MAX_VERTICES + 3;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam int RANDOM_BEATS = 400;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One answer from the block: the crossing parity and the status code.
  typedef struct packed {
    logic       in_poly;
    logic [1:0] status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pip_req_if #(.CoordBits(COORD_BITS)) req_if ();
  pip_res_if res_if ();

  point_in_polygon_test #(
    .MaxVertices(MAX_VERTICES),
    .CoordBits  (COORD_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  always #1 clk_i = ~clk_i;

  // Our copy of the polygon store, updated on every accepted request beat.
  coord_t  poly_x [MAX_VERTICES];
  coord_t  poly_y [MAX_VERTICES];
  int      poly_count = 0;
  logic    poly_overflow = 1'b0;

  answer_t pending_answers [$];

  int      failures = 0;
  int      beats_sent;
  int      cycle_count = 0;
  logic    no_idle;

  // Failures are all counted, but only the first ten are described.
  task automatic report_failure(input string msg);
    if (failures < 10) begin
      $display("[%0t] %s", $time, msg);
    end
    failures++;
  endtask

  // Ray-casting parity over every edge of the stored polygon. The edge from
  // the last vertex wraps back to vertex 0. The endpoints are put in order
  // of x, and the edge counts as a crossing when the query x lies in the
  // half-open span (left, right] and the query point is on or below the
  // line through the edge. The cross product is formed in 64 bits, so it
  // is exact for 16-bit coordinates.
  function automatic logic ray_parity(input coord_t qx, input coord_t qy);
    logic   parity;
    int     j;
    longint lx, ly, rx, ry, tmp;
    parity = 1'b0;
    for (int i = 0; i < poly_count; i++) begin
      j  = (i + 1 == poly_count) ? 0 : i + 1;
      lx = longint'(poly_x[i]);
      ly = longint'(poly_y[i]);
      rx = longint'(poly_x[j]);
      ry = longint'(poly_y[j]);
      if (rx < lx) begin
        tmp = lx; lx = rx; rx = tmp;
        tmp = ly; ly = ry; ry = tmp;
      end
      if (lx < longint'(qx) && longint'(qx) <= rx &&
          (rx - lx) * (longint'(qy) - ly) <= (ry - ly) * (longint'(qx) - lx)) begin
        parity = ~parity;
      end
    end
    return parity;
  endfunction

  // Applies one accepted request beat to our store. A query queues the
  // answer that the block owes for it; the other modes owe nothing.
  function automatic void apply_request(input logic [1:0] mode, input coord_t x,
                                        input coord_t y);
    answer_t ans;
    case (mode)
      MODE_CLEAR: begin
        poly_count    = 0;
        poly_overflow = 1'b0;
      end
      MODE_APPEND: begin
        if (poly_count < MAX_VERTICES) begin
          poly_x[poly_count] = x;
          poly_y[poly_count] = y;
          poly_count++;
        end else begin
          poly_overflow = 1'b1;
        end
      end
      MODE_QUERY: begin
        if (poly_overflow) begin
          ans.in_poly = 1'b0;
          ans.status  = STAT_OVERFLOW;
        end else if (poly_count < 3) begin
          ans.in_poly = 1'b0;
          ans.status  = STAT_TOO_FEW;
        end else begin
          ans.in_poly = ray_parity(x, y);
          ans.status  = STAT_OK;
        end
        pending_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endfunction

  // Compares one result beat with the oldest answer still owed.
  task automatic check_answer(input logic in_poly, input logic [1:0] status);
    answer_t want;
    if (pending_answers.size() == 0) begin
      report_failure($sformatf("result beat with none owed: in_poly=%0b status=%0d",
                               in_poly, status));
    end else begin
      want = pending_answers.pop_front();
      if (in_poly !== want.in_poly || status !== want.status) begin
        report_failure($sformatf("result mismatch: in_poly %0b (want %0b), status %0d (want %0d)",
                                 in_poly, want.in_poly, status, want.status));
      end
    end
  endtask

  // Both handshakes are judged at the rising edge, from values that were
  // set at the falling edge before it. A result is checked before the
  // request of the same edge is applied, although a query never completes
  // in the cycle in which it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        check_answer(res_if.inside_res, res_if.status);
      end
      if (req_if.valid && req_if.ready) begin
        apply_request(req_if.mode, req_if.coord_x, req_if.coord_y);
      end
    end
  end

  // The receiver stalls at random unless the quiet stretch is on.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready = 1'b0;
    end else begin
      res_if.ready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sends one request beat. It is entered and left at a falling edge. The
  // beat is held until the block takes it at a rising edge; valid is then
  // dropped at the next falling edge, unless the next call raises it again
  // straight away in the same step.
  task automatic send_beat(input logic [1:0] mode, input coord_t x, input coord_t y);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   = 1'b1;
    req_if.mode    = mode;
    req_if.coord_x = x;
    req_if.coord_y = y;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    beats_sent++;
  endtask

  // A coordinate within +/- span, or anywhere in the 16-bit range when the
  // span is zero. Small spans make coincident vertices, vertical edges and
  // points exactly on an edge common.
  function automatic coord_t pick_coord(input int span);
    if (span == 0) begin
      return coord_t'($urandom());
    end
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Queries on a store with fewer than three vertices must report so, and
  // the unused mode must leave the store as it was.
  task automatic test_too_few_vertices();
    send_beat(MODE_QUERY, 16'sd0, 16'sd0);
    send_beat(MODE_APPEND, 16'sd0, 16'sd0);
    send_beat(MODE_APPEND, 16'sd10, 16'sd0);
    send_beat(MODE_QUERY, 16'sd5, 16'sd1);
    send_beat(MODE_UNUSED, 16'sd5, 16'sd5);
    send_beat(MODE_QUERY, 16'sd5, -16'sd1);
  endtask

  // A square on the extremes of the coordinate range, with queries inside,
  // on each side and on one corner. The cross product reaches its largest
  // size here.
  task automatic test_extreme_square();
    send_beat(MODE_CLEAR, 16'sd0, 16'sd0);
    send_beat(MODE_APPEND, -16'sd32768, -16'sd32768);
    send_beat(MODE_APPEND, 16'sd32767, -16'sd32768);
    send_beat(MODE_UNUSED, -16'sd1, -16'sd1);
    send_beat(MODE_APPEND, 16'sd32767, 16'sd32767);
    send_beat(MODE_APPEND, -16'sd32768, 16'sd32767);
    send_beat(MODE_QUERY, 16'sd0, 16'sd0);
    send_beat(MODE_QUERY, -16'sd32768, 16'sd0);
    send_beat(MODE_QUERY, 16'sd32767, 16'sd0);
    send_beat(MODE_QUERY, 16'sd0, 16'sd32767);
    send_beat(MODE_QUERY, 16'sd32767, 16'sd32767);
    send_beat(MODE_QUERY, -16'sd32767, -16'sd32768);
  endtask

  // A triangle with a vertical edge and a repeated vertex, queried on its
  // edges, where the half-open span and the zero cross product decide
  // the answer.
  task automatic test_degenerate_edges();
    send_beat(MODE_CLEAR, 16'sd0, 16'sd0);
    send_beat(MODE_APPEND, 16'sd0, 16'sd0);
    send_beat(MODE_APPEND, 16'sd8, 16'sd0);
    send_beat(MODE_APPEND, 16'sd8, 16'sd0);
    send_beat(MODE_APPEND, 16'sd8, 16'sd8);
    send_beat(MODE_QUERY, 16'sd8, 16'sd4);
    send_beat(MODE_QUERY, 16'sd4, 16'sd4);
    send_beat(MODE_QUERY, 16'sd4, 16'sd0);
  endtask

  // Fills the store to capacity, queries the full polygon, then overflows
  // it. An overflowed store answers with its own status until a clear.
  task automatic test_store_overflow();
    send_beat(MODE_CLEAR, 16'sd0, 16'sd0);
    for (int i = 0; i < MAX_VERTICES; i++) begin
      send_beat(MODE_APPEND, pick_coord(1000), pick_coord(1000));
    end
    send_beat(MODE_QUERY, pick_coord(1000), pick_coord(1000));
    send_beat(MODE_APPEND, pick_coord(0), pick_coord(0));
    send_beat(MODE_QUERY, pick_coord(1000), pick_coord(1000));
    send_beat(MODE_APPEND, pick_coord(0), pick_coord(0));
    send_beat(MODE_QUERY, pick_coord(0), pick_coord(0));
    send_beat(MODE_CLEAR, 16'sd0, 16'sd0);
    send_beat(MODE_QUERY, 16'sd0, 16'sd0);
  endtask

  // The bulk of the traffic: mostly whole sequences of a clear, a polygon
  // and a few queries, with now and then a burst of stray beats of any
  // mode. Most polygons are small; a few fill or overflow the store.
  // Queries often share an x with a vertex or sit on one, as those are
  // the points where the crossing test is most delicate.
  task automatic test_random_polygons();
    coord_t vx [MAX_VERTICES + 2];
    coord_t vy [MAX_VERTICES + 2];
    int     first_beat;
    int     n_vert;
    int     span;
    int     pick;
    coord_t qx, qy;
    first_beat = beats_sent;
    while (beats_sent < first_beat + RANDOM_BEATS) begin
      // One long stretch in the middle runs with no idling on either side.
      no_idle = (beats_sent > first_beat + RANDOM_BEATS / 3) &&
                (beats_sent < first_beat + RANDOM_BEATS / 2);
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 4)) begin
          send_beat(2'($urandom()), pick_coord(0), pick_coord(0));
        end
      end else begin
        case ($urandom_range(0, 2))
          0: span = 8;
          1: span = 1000;
          default: span = 0;
        endcase
        if ($urandom_range(0, 19) == 0) begin
          n_vert = $urandom_range(MAX_VERTICES - 2, MAX_VERTICES + 2);
        end else if ($urandom_range(0, 9) == 0) begin
          n_vert = $urandom_range(0, 2);
        end else begin
          n_vert = $urandom_range(3, 8);
        end
        send_beat(MODE_CLEAR, pick_coord(0), pick_coord(0));
        for (int i = 0; i < n_vert; i++) begin
          vx[i] = pick_coord(span);
          vy[i] = pick_coord(span);
          send_beat(MODE_APPEND, vx[i], vy[i]);
          if ($urandom_range(0, 49) == 0) begin
            send_beat(MODE_UNUSED, pick_coord(0), pick_coord(0));
          end
        end
        repeat ($urandom_range(1, 6)) begin
          qx   = pick_coord(span);
          qy   = pick_coord(span);
          pick = (n_vert > 0) ? $urandom_range(0, n_vert - 1) : 0;
          case ($urandom_range(0, 3))
            0: if (n_vert > 0) qx = vx[pick];
            1: if (n_vert > 0) begin
              qx = vx[pick];
              qy = vy[pick];
            end
            default: begin
            end
          endcase
          send_beat(MODE_QUERY, qx, qy);
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_CLEAR;
    req_if.coord_x = '0;
    req_if.coord_y = '0;
    no_idle        = 1'b0;
    beats_sent     = 0;

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_too_few_vertices();
    test_extreme_square();
    test_degenerate_edges();
    test_store_overflow();
    test_random_polygons();

    // Wait for every owed answer, then long enough for a full query to
    // come out, so that a stray extra result beat is still caught.
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (QUERY_CYCLES + 16) @(posedge clk_i);

    if (failures == 0 && pending_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
